FILE: rtl/itoa_pkg.sv
// shared types, codes and character constants of the integer to ascii formatter
`default_nettype none
package itoa_pkg;

   localparam int unsigned CMD_W = 2;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned TOTAL_W = 5;

   localparam logic [CMD_W-1:0] CMD_DEC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HEX_LOWER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HEX_UPPER = 2'd2;
   localparam logic [CMD_W-1:0] CMD_POINTER = 2'd3;

   localparam logic [CHAR_W-1:0] DIGIT_BIAS = 8'd48;
   localparam logic [CHAR_W-1:0] LOWER_BIAS = 8'd87;
   localparam logic [CHAR_W-1:0] UPPER_BIAS = 8'd55;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_X = 8'h78;

   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_W = 4 * BCD_DIGITS;
   localparam int unsigned NIBBLES = VALUE_W / 4;
   localparam int unsigned DEC_BITS = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_PREFIX,
      ST_DIGITS,
      ST_NIL
   } state_type;

   // characters of the null pointer text "(nil)"
   function automatic logic [CHAR_W-1:0] nil_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         3'd0: c = 8'h28;
         3'd1: c = 8'h6E;
         3'd2: c = 8'h69;
         3'd3: c = 8'h6C;
         default: c = 8'h29;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/itoa_if.sv
// request and response channel interfaces of the integer to ascii formatter
`default_nettype none
interface itoa_req_if;
   logic                              valid;
   logic                              ready;
   logic [itoa_pkg::CMD_W-1:0]        cmd;
   logic [itoa_pkg::VALUE_W-1:0]      value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink (input valid, input cmd, input value, output ready);
endinterface

interface itoa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [itoa_pkg::CHAR_W-1:0]       char_code;
   logic                              last;
   logic [itoa_pkg::TOTAL_W-1:0]      total_chars;

   modport source (output valid, output char_code, output last, output total_chars,
                   input ready);
   modport sink (input valid, input char_code, input last, input total_chars,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/integer_to_ascii_formatter_core.sv
// integer to ascii formatter: one command beat in, its characters out one beat each
//
// usage
//   req_chan carries cmd and value; a beat is taken when valid and ready are high.
//   cmd selects unsigned decimal, lower or upper hex of the low 32 bits, or a
//   64-bit pointer ("0x" plus lower hex, "(nil)" for zero).
//   rsp_chan gives one character per beat, most significant digit first; the
//   final beat has last set and total_chars holding the run length.
// sequence of an item
//   req_chan.ready is high only while the sequencer is idle, one item at a time.
//   hex: a load, leading-zero strip shifts (one nibble each), a strip exit, then one
//   character per digit.
//   pointer: a load, strip shifts, a strip exit, the "0x" prefix and one character
//   per digit; the null pointer gives "(nil)" after its load instead.
//   decimal: a load, double-dabble steps on the shared add-3/shift unit, strip
//   shifts, a strip exit and one character per digit.
//   an output register parts the sides; when rsp_chan stalls the sequencer
//   holds its character and waits.
// reset
//   synchronous active-high reset returns to idle and drops rsp_chan.valid.
`default_nettype none
module integer_to_ascii_formatter_core (
   input  wire logic      clock,
   input  wire logic      reset,
   itoa_req_if.sink       req_chan,
   itoa_rsp_if.source     rsp_chan
);

   itoa_pkg::state_type state_ff, state_in;

   logic [itoa_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [itoa_pkg::VALUE_W-1:0] work_ff, work_in;    // digits, msb nibble emitted first
   logic [itoa_pkg::BCD_W-1:0]   bcd_ff, bcd_in;      // decimal digits under construction
   logic [4:0]                   cnt_ff, cnt_in;      // dabble bit count, then digits left
   logic [4:0]                   len_ff, len_in;      // run length
   logic [2:0]                   pos_ff, pos_in;      // prefix / nil character index

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [itoa_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic                         out_free;
   logic [itoa_pkg::BCD_W-1:0]   bcd_adj;
   logic [3:0]                   top_nib;
   logic [itoa_pkg::CHAR_W-1:0]  nib_char;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign top_nib  = work_ff[itoa_pkg::VALUE_W-1 -: 4];

   // shared add-3 stage of the double dabble
   always_comb begin
      for (int i = 0; i < int'(itoa_pkg::BCD_DIGITS); i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   // ascii code of the leading nibble
   always_comb begin
      if (top_nib > 4'd9) begin
         nib_char = {4'd0, top_nib} + ((cmd_ff == itoa_pkg::CMD_HEX_UPPER)
                                       ? itoa_pkg::UPPER_BIAS : itoa_pkg::LOWER_BIAS);
      end else begin
         nib_char = {4'd0, top_nib} + itoa_pkg::DIGIT_BIAS;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      work_in      = work_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_total_in = rsp_total_ff;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         itoa_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in = req_chan.cmd;
               pos_in = 3'd0;
               cnt_in = 5'(itoa_pkg::NIBBLES);
               bcd_in = '0;
               unique case (req_chan.cmd)
                  itoa_pkg::CMD_DEC: begin
                     work_in  = {32'd0, req_chan.value[31:0]};
                     cnt_in   = 5'd0;
                     state_in = itoa_pkg::ST_CONVERT;
                  end
                  itoa_pkg::CMD_HEX_LOWER, itoa_pkg::CMD_HEX_UPPER: begin
                     work_in  = {32'd0, req_chan.value[31:0]};
                     state_in = itoa_pkg::ST_STRIP;
                  end
                  default: begin
                     work_in  = req_chan.value;
                     state_in = (req_chan.value == '0) ? itoa_pkg::ST_NIL
                                                        : itoa_pkg::ST_STRIP;
                  end
               endcase
            end
         end

         itoa_pkg::ST_CONVERT: begin
            // one binary bit shifted into the bcd digits per cycle
            bcd_in  = {bcd_adj[itoa_pkg::BCD_W-2:0], work_ff[itoa_pkg::DEC_BITS-1]};
            work_in = work_ff << 1;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(itoa_pkg::DEC_BITS - 1)) begin
               work_in  = {{(itoa_pkg::VALUE_W - itoa_pkg::BCD_W){1'b0}}, bcd_in};
               cnt_in   = 5'(itoa_pkg::NIBBLES);
               state_in = itoa_pkg::ST_STRIP;
            end
         end

         itoa_pkg::ST_STRIP: begin
            // drop leading zero nibbles, keeping at least one digit
            if (top_nib == 4'd0 && cnt_ff > 5'd1) begin
               work_in = work_ff << 4;
               cnt_in  = cnt_ff - 5'd1;
            end else begin
               len_in   = cnt_ff + ((cmd_ff == itoa_pkg::CMD_POINTER) ? 5'd2 : 5'd0);
               state_in = (cmd_ff == itoa_pkg::CMD_POINTER) ? itoa_pkg::ST_PREFIX
                                                             : itoa_pkg::ST_DIGITS;
            end
         end

         itoa_pkg::ST_PREFIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = (pos_ff == 3'd0) ? itoa_pkg::CHAR_ZERO : itoa_pkg::CHAR_X;
               rsp_last_in  = 1'b0;
               rsp_total_in = '0;
               pos_in       = pos_ff + 3'd1;
               if (pos_ff != 3'd0) begin
                  state_in = itoa_pkg::ST_DIGITS;
               end
            end
         end

         itoa_pkg::ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = nib_char;
               rsp_last_in  = (cnt_ff == 5'd1);
               rsp_total_in = (cnt_ff == 5'd1) ? len_ff : '0;
               work_in      = work_ff << 4;
               cnt_in       = cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_in = itoa_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            // null pointer text
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itoa_pkg::nil_char(pos_ff);
               rsp_last_in  = (pos_ff == 3'd4);
               rsp_total_in = (pos_ff == 3'd4) ? 5'd5 : '0;
               pos_in       = pos_ff + 3'd1;
               if (pos_ff == 3'd4) begin
                  state_in = itoa_pkg::ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      work_ff      <= work_in;
      bcd_ff       <= bcd_in;
      cnt_ff       <= cnt_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.char_code   = rsp_char_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.total_chars = rsp_total_ff;

endmodule
`default_nettype wire

FILE: tb/sv/tb_integer_to_ascii_formatter_core.sv
// self-checking testbench of the integer to ascii formatter core
`default_nettype none
module tb_integer_to_ascii_formatter_core;

   // longest stretch without any accepted beat before the run is declared hung
   localparam int unsigned IDLE_LIMIT = 2000;
   // quiet cycles after the last character
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int unsigned PAUSE_AT = 200;
   localparam string NIL_TEXT = "(nil)";

   typedef logic [itoa_pkg::CHAR_W-1:0] text_q_type[$];

   // one expected character beat
   typedef struct packed {
      logic [itoa_pkg::CHAR_W-1:0]  char_code;
      logic                         last;
      logic [itoa_pkg::TOTAL_W-1:0] total_chars;
   } glyph_type;

   // expected character store and text predictor
   class text_board;
      glyph_type   pending_chars[$];
      int unsigned mismatches;
      int unsigned chars_checked;
      int unsigned cmd_count[4];

      task report_mismatch(input string msg);
         mismatches++;
         if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      // hex digits of v, most significant first, no leading zeros
      function text_q_type hex_text(input logic [itoa_pkg::VALUE_W-1:0] v,
                                    input logic [itoa_pkg::CHAR_W-1:0] bias);
         text_q_type                   text;
         logic [itoa_pkg::VALUE_W-1:0] rest;
         logic [3:0]                   nib;
         rest = v;
         do begin
            nib = rest[3:0];
            text.push_front((nib > 4'd9) ? bias + itoa_pkg::CHAR_W'(nib)
                                         : itoa_pkg::DIGIT_BIAS + itoa_pkg::CHAR_W'(nib));
            rest = rest >> 4;
         end while (rest != '0);
         return text;
      endfunction

      // full character text of one request
      function text_q_type spell_value(input logic [itoa_pkg::CMD_W-1:0] cmd,
                                       input logic [itoa_pkg::VALUE_W-1:0] value);
         text_q_type  text;
         logic [31:0] dec_rest;
         case (cmd)
            itoa_pkg::CMD_DEC: begin
               dec_rest = value[31:0];
               do begin
                  text.push_front(itoa_pkg::DIGIT_BIAS
                                  + itoa_pkg::CHAR_W'(dec_rest % 32'd10));
                  dec_rest = dec_rest / 32'd10;
               end while (dec_rest != 32'd0);
            end
            itoa_pkg::CMD_HEX_LOWER:
               text = hex_text({32'd0, value[31:0]}, itoa_pkg::LOWER_BIAS);
            itoa_pkg::CMD_HEX_UPPER:
               text = hex_text({32'd0, value[31:0]}, itoa_pkg::UPPER_BIAS);
            default: begin
               if (value == '0) begin
                  for (int i = 0; i < NIL_TEXT.len(); i++)
                     text.push_back(itoa_pkg::CHAR_W'(NIL_TEXT[i]));
               end else begin
                  text = hex_text(value, itoa_pkg::LOWER_BIAS);
                  text.push_front(itoa_pkg::CHAR_X);
                  text.push_front(itoa_pkg::CHAR_ZERO);
               end
            end
         endcase
         return text;
      endfunction

      function void note_request(input logic [itoa_pkg::CMD_W-1:0] cmd,
                                 input logic [itoa_pkg::VALUE_W-1:0] value);
         text_q_type text;
         glyph_type  g;
         text = spell_value(cmd, value);
         cmd_count[cmd]++;
         for (int k = 0; k < text.size(); k++) begin
            g.char_code   = text[k];
            g.last        = (k == text.size() - 1);
            g.total_chars = g.last ? itoa_pkg::TOTAL_W'(text.size()) : '0;
            pending_chars.push_back(g);
         end
      endfunction

      task check_char(input logic [itoa_pkg::CHAR_W-1:0] char_code, input logic last,
                      input logic [itoa_pkg::TOTAL_W-1:0] total_chars);
         glyph_type exp_g;
         chars_checked++;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("character 0x%02h with nothing pending", char_code));
         end else begin
            exp_g = pending_chars.pop_front();
            if (char_code !== exp_g.char_code)
               report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                         char_code, exp_g.char_code));
            if (last !== exp_g.last)
               report_mismatch($sformatf("last %b, wanted %b", last, exp_g.last));
            if (total_chars !== exp_g.total_chars)
               report_mismatch($sformatf("total_chars %0d, wanted %0d",
                                         total_chars, exp_g.total_chars));
         end
      endtask

      function int unsigned pending_count();
         return pending_chars.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   itoa_req_if req_chan ();
   itoa_rsp_if rsp_chan ();

   text_board   board = new();
   int unsigned idle_cycles = 0;

   integer_to_ascii_formatter_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // every character beat is compared against the oldest pending expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_char(rsp_chan.char_code, rsp_chan.last, rsp_chan.total_chars);
   end

   // watchdog: any accepted beat on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver back pressure: each stretch draws one of these patterns at random
   //   0 always ready, 1 random coin, 2 periodic gap, 3 long stalls with short windows
   initial begin
      int unsigned stretch;
      int unsigned mode;
      int unsigned hold;
      logic        level;
      stretch = 0;
      mode = 0;
      hold = 0;
      level = 1'b0;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(20, 300);
         end
         stretch--;
         case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 99) < 60);
            2: rsp_chan.ready <= ((stretch % 5) != 0);
            default: begin
               if (hold == 0) begin
                  level = ~level;
                  hold = level ? $urandom_range(1, 4) : $urandom_range(1, 12);
               end
               hold--;
               rsp_chan.ready <= level;
            end
         endcase
      end
   end

   // present one request beat, wait for it to be taken, then idle for the given gap;
   // called at a falling edge and returns at one, so valid is never dropped and
   // raised in the same step
   task send_item(input logic [itoa_pkg::CMD_W-1:0] cmd,
                  input logic [itoa_pkg::VALUE_W-1:0] value,
                  input int unsigned gap);
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(cmd, value);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         req_chan.value <= {$urandom, $urandom};
         repeat (gap) @(negedge clock);
      end
   endtask

   // values of varied digit counts; bits above the used width show up too
   function automatic logic [itoa_pkg::VALUE_W-1:0] pick_value();
      logic [itoa_pkg::VALUE_W-1:0] v;
      int unsigned                  bits;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = v & 64'hFF;
         1, 2: begin
            bits = $urandom_range(1, 64);
            if (bits < 64)
               v = v & ((64'd1 << bits) - 64'd1);
         end
         3: v = v;
         4: v = {v[63:32], 32'd0};
         default: begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = '1;
               2: v = {v[63:32], 32'hFFFF_FFFF};
               default: v = 64'd1 << $urandom_range(0, 63);
            endcase
         end
      endcase
      return v;
   endfunction

   initial begin
      int unsigned sent;
      int unsigned burst_left;
      int unsigned gap;
      req_chan.valid = 1'b0;
      req_chan.cmd   = itoa_pkg::CMD_DEC;
      req_chan.value = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zeros, full widths, digit and letter boundaries, ignored upper bits,
      // the null pointer and pointers of several lengths
      send_item(itoa_pkg::CMD_DEC, 64'd0, 0);
      send_item(itoa_pkg::CMD_DEC, 64'h0000_0000_FFFF_FFFF, 1);
      send_item(itoa_pkg::CMD_DEC, 64'd9, 0);
      send_item(itoa_pkg::CMD_DEC, 64'd10, 2);
      send_item(itoa_pkg::CMD_DEC, 64'd1000000000, 0);
      send_item(itoa_pkg::CMD_DEC, 64'hFFFF_FFFF_0000_0000, 0);
      send_item(itoa_pkg::CMD_DEC, 64'hDEAD_BEEF_0000_007B, 1);
      send_item(itoa_pkg::CMD_HEX_LOWER, 64'd0, 0);
      send_item(itoa_pkg::CMD_HEX_LOWER, 64'h0000_0000_FFFF_FFFF, 0);
      send_item(itoa_pkg::CMD_HEX_LOWER, 64'h9, 3);
      send_item(itoa_pkg::CMD_HEX_LOWER, 64'hA, 0);
      send_item(itoa_pkg::CMD_HEX_LOWER, 64'h0000_0000_89AB_CDEF, 0);
      send_item(itoa_pkg::CMD_HEX_LOWER, 64'h1234_5678_0000_0000, 1);
      send_item(itoa_pkg::CMD_HEX_UPPER, 64'd0, 0);
      send_item(itoa_pkg::CMD_HEX_UPPER, 64'h0000_0000_FFFF_FFFF, 0);
      send_item(itoa_pkg::CMD_HEX_UPPER, 64'hF, 2);
      send_item(itoa_pkg::CMD_HEX_UPPER, 64'hAAAA_AAAA_0123_4567, 0);
      send_item(itoa_pkg::CMD_POINTER, 64'd0, 0);
      send_item(itoa_pkg::CMD_POINTER, 64'hFFFF_FFFF_FFFF_FFFF, 1);
      send_item(itoa_pkg::CMD_POINTER, 64'd1, 0);
      send_item(itoa_pkg::CMD_POINTER, 64'h8000_0000_0000_0000, 0);
      send_item(itoa_pkg::CMD_POINTER, 64'h0000_0000_FFFF_FFFF, 0);
      send_item(itoa_pkg::CMD_POINTER, 64'hFEDC_BA98_7654_3210, 4);

      // random part in bursts; a quarter of the bursts keep going with no gap after
      sent = 0;
      burst_left = 0;
      while (sent < RANDOM_ITEMS) begin
         if (burst_left == 0)
            burst_left = $urandom_range(1, 12);
         burst_left--;
         gap = 0;
         if (burst_left == 0 && $urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 20);
         if (sent + 1 == PAUSE_AT || sent + 1 == RANDOM_ITEMS)
            gap = 1;
         send_item(itoa_pkg::CMD_W'($urandom_range(0, 3)), pick_value(), gap);
         sent++;
         // hold off once until the block has drained completely
         if (sent == PAUSE_AT) begin
            while (board.pending_count() != 0) @(negedge clock);
         end
      end

      // drain and let any stray character beat surface
      while (board.pending_count() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests: %0d decimal, %0d lower hex, %0d upper hex, %0d pointer",
               board.cmd_count.sum(),
               board.cmd_count[itoa_pkg::CMD_DEC], board.cmd_count[itoa_pkg::CMD_HEX_LOWER],
               board.cmd_count[itoa_pkg::CMD_HEX_UPPER],
               board.cmd_count[itoa_pkg::CMD_POINTER]);
      $display("%0d character beats compared, %0d mismatches",
               board.chars_checked, board.mismatches);
      if (board.mismatches == 0 && board.pending_count() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
